// ===== rtl/srpm_pkg.sv =====
// Shared types, constants and helpers of the simplex refinement point matrix block.
package srpm_pkg;

    localparam int FRAC_BITS  = 6;
    localparam int COORD_W    = FRAC_BITS + 1;
    localparam int NVERT      = 5;
    localparam int NDIM       = 4;
    localparam int NCHUNK     = 6;
    localparam int CHUNK_BITS = 6;
    localparam int NRULES     = 16;
    localparam int CODE_W     = 32;
    localparam int EXT_W      = NCHUNK * CHUNK_BITS;

    typedef logic [COORD_W-1:0] coord_t;
    typedef coord_t [NDIM-1:0] vertex_t;
    typedef logic [2:0] vidx_t;
    typedef logic [2:0] step_t;
    typedef logic [3:0] rule_t;

    localparam coord_t COORD_ONE = coord_t'(1) << FRAC_BITS;
    localparam vidx_t  LAST_VIDX = vidx_t'(NVERT - 1);

    // per rule: five bytes, vertex 0 in the top byte; hi nibble p, lo nibble q
    localparam logic [8*NVERT-1:0] RULE_PAIRS [NRULES] = '{
        40'h03_04_14_24_34,
        40'h00_01_02_03_04,
        40'h01_11_12_13_14,
        40'h02_12_22_23_24,
        40'h03_13_23_33_34,
        40'h04_14_24_34_44,
        40'h01_02_12_13_14,
        40'h01_02_03_13_14,
        40'h01_02_03_04_14,
        40'h02_12_13_23_24,
        40'h02_12_13_14_24,
        40'h02_03_13_23_24,
        40'h02_03_13_14_24,
        40'h02_03_04_14_24,
        40'h03_13_23_24_34,
        40'h03_13_14_24_34
    };

    typedef struct packed {
        logic  load;
        logic  apply;
        logic  shift;
        step_t chunk_idx;
    } srpm_cmd_t;

    typedef struct packed {
        step_t chain_len;
        logic  bad;
    } srpm_status_t;

    function automatic logic [CHUNK_BITS-1:0] chunk_sel(input logic [CODE_W-1:0] code,
                                                        input step_t idx);
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] shifted;
        ext     = {{(EXT_W-CODE_W){1'b0}}, code};
        shifted = ext >> (CHUNK_BITS * int'(idx));
        return shifted[CHUNK_BITS-1:0];
    endfunction

endpackage

// ===== rtl/srpm_if.sv =====
// Request channel interfaces: refinement code in, vertex results out.
interface srpm_code_if;
    logic                          valid;
    logic                          ready;
    logic [srpm_pkg::CODE_W-1:0]   transform_code;
    modport source (output valid, output transform_code, input ready);
    modport sink   (input valid, input transform_code, output ready);
endinterface

interface srpm_vertex_if;
    logic                  valid;
    logic                  ready;
    srpm_pkg::vidx_t       vertex_number;
    srpm_pkg::coord_t      coord_x;
    srpm_pkg::coord_t      coord_y;
    srpm_pkg::coord_t      coord_z;
    srpm_pkg::coord_t      coord_w;
    logic                  invalid_code;
    logic                  last_vertex;
    modport source (output valid, output vertex_number, output coord_x, output coord_y,
                    output coord_z, output coord_w, output invalid_code,
                    output last_vertex, input ready);
    modport sink   (input valid, input vertex_number, input coord_x, input coord_y,
                    input coord_z, input coord_w, input invalid_code,
                    input last_vertex, output ready);
endinterface

// ===== rtl/srpm_datapath.sv =====
// Datapath: vertex registers, midpoint rule unit, chain length and validity check.
module srpm_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [srpm_pkg::CODE_W-1:0] code,
    input  srpm_pkg::srpm_cmd_t         cmd,
    output srpm_pkg::srpm_status_t      status,
    output srpm_pkg::vertex_t           head,
    output logic                        invalid
);

    logic [srpm_pkg::CODE_W-1:0] code_reg;
    srpm_pkg::vertex_t           vert_reg  [srpm_pkg::NVERT];
    srpm_pkg::vertex_t           vert_next [srpm_pkg::NVERT];
    srpm_pkg::step_t             len_reg, len_next;
    logic                        bad_reg, bad_next;
    srpm_pkg::vertex_t           mid       [srpm_pkg::NVERT];

    // chain length and rule check on the incoming code
    always_comb
    begin
        logic [srpm_pkg::CHUNK_BITS-1:0] ch;
        len_next = '0;
        bad_next = 1'b0;
        for (int c = 0; c < srpm_pkg::NCHUNK; c++)
        begin
            ch = srpm_pkg::chunk_sel(code, srpm_pkg::step_t'(c));
            if (ch != '0)
                len_next = srpm_pkg::step_t'(c + 1);
        end
        for (int c = 0; c < srpm_pkg::NCHUNK; c++)
        begin
            ch = srpm_pkg::chunk_sel(code, srpm_pkg::step_t'(c));
            if (c < int'(len_next) && (ch[4:0] == 5'd0 || ch[4:0] > 5'(srpm_pkg::NRULES)))
                bad_next = 1'b1;
        end
    end

    // one refinement step: every new vertex is the midpoint of two old ones
    always_comb
    begin
        logic [srpm_pkg::CHUNK_BITS-1:0] ch;
        srpm_pkg::rule_t                 rule;
        logic [7:0]                      pair;
        srpm_pkg::vidx_t                 p, q;
        logic [srpm_pkg::COORD_W:0]      sum;
        ch   = srpm_pkg::chunk_sel(code_reg, cmd.chunk_idx);
        rule = srpm_pkg::rule_t'(ch[4:0] - 5'd1);
        for (int k = 0; k < srpm_pkg::NVERT; k++)
        begin
            pair = srpm_pkg::RULE_PAIRS[rule][8*(srpm_pkg::NVERT-1-k) +: 8];
            p    = pair[6:4];
            q    = pair[2:0];
            for (int i = 0; i < srpm_pkg::NDIM; i++)
            begin
                sum          = {1'b0, vert_reg[p][i]} + {1'b0, vert_reg[q][i]};
                mid[k][i]    = sum[srpm_pkg::COORD_W:1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < srpm_pkg::NVERT; k++)
            vert_next[k] = vert_reg[k];
        if (cmd.load)
        begin
            for (int k = 0; k < srpm_pkg::NVERT; k++)
                for (int i = 0; i < srpm_pkg::NDIM; i++)
                    vert_next[k][i] = (k == i + 1) ? srpm_pkg::COORD_ONE : '0;
        end
        else if (cmd.apply)
        begin
            for (int k = 0; k < srpm_pkg::NVERT; k++)
                vert_next[k] = mid[k];
        end
        else if (cmd.shift)
        begin
            for (int k = 0; k < srpm_pkg::NVERT - 1; k++)
                vert_next[k] = vert_reg[k+1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < srpm_pkg::NVERT; k++)
            vert_reg[k] <= vert_next[k];
        if (cmd.load)
            code_reg <= code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            bad_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            len_reg <= len_next;
            bad_reg <= bad_next;
        end
    end

    assign status.chain_len = len_reg;
    assign status.bad       = bad_reg;
    assign head             = bad_reg ? '0 : vert_reg[0];
    assign invalid          = bad_reg;

`ifndef SYNTH
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= srpm_pkg::step_t'(srpm_pkg::NCHUNK))
        else $error("chain length beyond chunk count");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.apply, cmd.shift}) <= 1)
        else $error("conflicting datapath commands");
    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && code == '0 |=> len_reg == '0 && !bad_reg)
        else $error("zero code must give empty valid chain");
`endif

endmodule

// ===== rtl/srpm_ctrl.sv =====
// Controller: sequences load, refinement steps and the five vertex requests.
module srpm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   code_valid,
    output logic                   code_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  srpm_pkg::srpm_status_t status,
    output srpm_pkg::srpm_cmd_t    cmd,
    output srpm_pkg::vidx_t        vertex_number,
    output logic                   last_vertex
);

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_STEP, S_EMIT} state_t;

    state_t          state_reg, state_next;
    srpm_pkg::step_t step_reg, step_next;
    srpm_pkg::vidx_t vert_reg, vert_next;

    assign code_ready    = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_EMIT);
    assign vertex_number = vert_reg;
    assign last_vertex   = (vert_reg == srpm_pkg::LAST_VIDX);

    always_comb
    begin
        cmd.load      = code_valid && code_ready;
        cmd.apply     = (state_reg == S_STEP) && (step_reg != '0);
        cmd.shift     = out_valid && out_ready;
        cmd.chunk_idx = step_reg - 3'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        vert_next  = vert_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // an invalid chain skips all steps; coordinates are masked anyway
                step_next  = status.bad ? '0 : status.chain_len;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (step_reg == '0)
                begin
                    vert_next  = '0;
                    state_next = S_EMIT;
                end
                else
                    step_next = step_reg - 3'd1;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (last_vertex)
                        state_next = S_IDLE;
                    else
                        vert_next = vert_reg + 3'd1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            vert_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            vert_reg  <= vert_next;
        end
    end

`ifndef SYNTH
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_ready |=> !code_ready)
        else $error("new code taken while one is in flight");
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_vertex |=> state_reg == S_IDLE)
        else $error("run did not end after last vertex");
    a_emit_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> vert_reg == '0)
        else $error("vertex run does not start at vertex zero");
`endif

endmodule

// ===== rtl/simplex_refinement_point_matrix_core.sv =====
// Top level of the simplex refinement point matrix block.
// Usage:
//   code_ch   (sink): one 32-bit transform_code per request. The code is cut into
//             6-bit chunks from the low end; each chunk up to the highest nonzero
//             one selects a midpoint rule (low five bits minus one).
//   vertex_ch (source): five requests per code, vertices 0..4 of the refined
//             simplex, coordinates with 6 fractional bits; last_vertex marks
//             vertex 4. A chunk outside rules 0..15 sets invalid_code and zeroes
//             the coordinates of all five vertices.
// Timing: one code at a time. After the code is taken there is one load state,
//   then one step state per chain step (0 to 6) plus one, then the five vertex
//   requests, one per cycle when the receiver is ready; the next code can be
//   taken the cycle after the last vertex is taken. The number of chain steps
//   run on the single midpoint unit is the part that varies between codes.
// Stall: a stalled vertex holds its payload and the block waits; code_ch stays
//   not ready until the last vertex is taken.
// Reset: rst_n (asynchronous, active low) returns the controller to idle and
//   drops any run in flight.
module simplex_refinement_point_matrix_core (
    input  logic          clk,
    input  logic          rst_n,
    srpm_code_if.sink     code_ch,
    srpm_vertex_if.source vertex_ch
);

    srpm_pkg::srpm_cmd_t    cmd;
    srpm_pkg::srpm_status_t status;
    srpm_pkg::vertex_t      head;

    srpm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .code_valid    (code_ch.valid),
        .code_ready    (code_ch.ready),
        .out_valid     (vertex_ch.valid),
        .out_ready     (vertex_ch.ready),
        .status        (status),
        .cmd           (cmd),
        .vertex_number (vertex_ch.vertex_number),
        .last_vertex   (vertex_ch.last_vertex)
    );

    srpm_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .code    (code_ch.transform_code),
        .cmd     (cmd),
        .status  (status),
        .head    (head),
        .invalid (vertex_ch.invalid_code)
    );

    assign vertex_ch.coord_x = head[0];
    assign vertex_ch.coord_y = head[1];
    assign vertex_ch.coord_z = head[2];
    assign vertex_ch.coord_w = head[3];

endmodule
